### design/bfmb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmb_pkg
// Shared constants, operation codes and controller command type for the
// byte FIFO mailbox bridge.
// ----------------------------------------------------------------------------
package bfmb_pkg;

    localparam int FIFO_DEPTH_DEF = 16;
    localparam int FUNC_W         = 3;
    localparam int DATA_W         = 8;

    // byte returned by a master read of an empty receive FIFO
    localparam logic [DATA_W-1:0] EMPTY_BYTE = 8'hFF;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_MASTER_WRITE = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_MASTER_READ  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_TX_PUMP      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_RX_PUMP      = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_HOST_TAKE    = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_HOST_PUT     = 3'd5;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the operation on an accepted transfer
        logic fetch;    // registered read of both FIFO head entries
        logic exec;     // apply the operation and present the result
    } t_cmd;

endpackage

### design/byte_fifo_mailbox_bridge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_fifo_mailbox_bridge_unit
// Master-side byte FIFOs bridged to a host mailbox pair.
// ----------------------------------------------------------------------------
// Usage:
//   An operation (i_func, i_data) transfers in at a rising edge with start
//   high and busy low. busy then stays high while the operation runs.
//   Each operation yields one result on o_read_data, o_read_was_empty,
//   o_accepted and the four status flags, shown for one cycle with o_done.
//   Sequence: after the accepting edge the operation passes a fetch step,
//   a registered read of the FIFO memories, and then the execute step.
//   The result appears in the cycle where busy drops; a new operation may
//   transfer at the edge that ends the o_done cycle.
//   The receiver cannot stall: each result is valid only while o_done is
//   high and must be taken then.
//   Reset (synchronous, active low) empties both FIFOs, clears both
//   mailboxes and their flags, and sets the transmit-drained flag.
// ----------------------------------------------------------------------------
module byte_fifo_mailbox_bridge_unit #(
    parameter int FIFO_DEPTH = bfmb_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bfmb_pkg::FUNC_W-1:0] i_func,
    input  logic [bfmb_pkg::DATA_W-1:0] i_data,
    output logic                        o_done,
    output logic [bfmb_pkg::DATA_W-1:0] o_read_data,
    output logic                        o_read_was_empty,
    output logic                        o_accepted,
    output logic                        o_tx_flag,
    output logic                        o_tx_empty,
    output logic                        o_rx_flag,
    output logic                        o_rx_full
);

    bfmb_pkg::t_cmd cmd;

    // sequencer
    bfmb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // FIFOs, mailboxes and result
    bfmb_dpath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_func           (i_func),
        .i_data           (i_data),
        .o_done           (o_done),
        .o_read_data      (o_read_data),
        .o_read_was_empty (o_read_was_empty),
        .o_accepted       (o_accepted),
        .o_tx_flag        (o_tx_flag),
        .o_tx_empty       (o_tx_empty),
        .o_rx_flag        (o_rx_flag),
        .o_rx_full        (o_rx_full)
    );

endmodule

### design/bfmb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmb_ctrl
// Sequencer: accept an operation, fetch FIFO heads, execute.
// ----------------------------------------------------------------------------
module bfmb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output bfmb_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    // next state
    always_comb begin
        case (r_state)
            ST_IDLE:  n_state = start ? ST_FETCH : ST_IDLE;
            ST_FETCH: n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state and registered busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != ST_IDLE);
        end
    end

    // commands
    always_comb begin
        o_cmd.capture = start && (r_state == ST_IDLE);
        o_cmd.fetch   = (r_state == ST_FETCH);
        o_cmd.exec    = (r_state == ST_EXEC);
    end

    assign busy = r_busy;

endmodule

### design/bfmb_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfmb_dpath
// Two ring byte FIFOs, the two mailboxes, status flags and result registers.
// ----------------------------------------------------------------------------
module bfmb_dpath #(
    parameter int FIFO_DEPTH = bfmb_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bfmb_pkg::t_cmd              i_cmd,
    input  logic [bfmb_pkg::FUNC_W-1:0] i_func,
    input  logic [bfmb_pkg::DATA_W-1:0] i_data,
    output logic                        o_done,
    output logic [bfmb_pkg::DATA_W-1:0] o_read_data,
    output logic                        o_read_was_empty,
    output logic                        o_accepted,
    output logic                        o_tx_flag,
    output logic                        o_tx_empty,
    output logic                        o_rx_flag,
    output logic                        o_rx_full
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int DW    = bfmb_pkg::DATA_W;

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // latched operation
    logic [bfmb_pkg::FUNC_W-1:0] r_func;
    logic [DW-1:0]               r_data;

    // storage
    logic [DW-1:0] tx_mem [FIFO_DEPTH];
    logic [DW-1:0] rx_mem [FIFO_DEPTH];
    logic [DW-1:0] r_tx_q;
    logic [DW-1:0] r_rx_q;

    // control state
    logic [PTR_W-1:0] r_tx_rp, r_tx_wp, r_rx_rp, r_rx_wp;
    logic [PTR_W-1:0] n_tx_rp, n_tx_wp, n_rx_rp, n_rx_wp;
    logic [DW-1:0]    r_out_mb, r_in_mb, n_out_mb, n_in_mb;
    logic             r_out_vld, r_drained, r_in_vld, r_rx_full;
    logic             n_out_vld, n_drained, n_in_vld, n_rx_full;

    // result
    logic [DW-1:0] r_read_data, n_read_data;
    logic          r_was_empty, n_was_empty;
    logic          r_acc, n_acc;
    logic          r_done;

    logic tx_we, rx_we;

    // capture the accepted operation
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_data <= i_data;
        end
    end

    // transmit FIFO memory
    always_ff @(posedge i_clk) begin
        if (tx_we) begin
            tx_mem[r_tx_wp] <= r_data;
        end
        if (i_cmd.fetch) begin
            r_tx_q <= tx_mem[r_tx_rp];
        end
    end

    // receive FIFO memory
    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            rx_mem[r_rx_wp] <= r_in_mb;
        end
        if (i_cmd.fetch) begin
            r_rx_q <= rx_mem[r_rx_rp];
        end
    end

    // operation decode and next state
    always_comb begin
        n_tx_rp     = r_tx_rp;
        n_tx_wp     = r_tx_wp;
        n_rx_rp     = r_rx_rp;
        n_rx_wp     = r_rx_wp;
        n_out_mb    = r_out_mb;
        n_in_mb     = r_in_mb;
        n_out_vld   = r_out_vld;
        n_drained   = r_drained;
        n_in_vld    = r_in_vld;
        n_rx_full   = r_rx_full;
        n_read_data = '0;
        n_was_empty = 1'b0;
        n_acc       = 1'b0;
        tx_we       = 1'b0;
        rx_we       = 1'b0;
        case (r_func)
            bfmb_pkg::FUNC_MASTER_WRITE: begin
                if (f_next(r_tx_wp) != r_tx_rp) begin
                    tx_we     = i_cmd.exec;
                    n_tx_wp   = f_next(r_tx_wp);
                    n_drained = 1'b0;
                    n_acc     = 1'b1;
                end
            end
            bfmb_pkg::FUNC_MASTER_READ: begin
                if (r_rx_rp == r_rx_wp) begin
                    n_read_data = bfmb_pkg::EMPTY_BYTE;
                    n_was_empty = 1'b1;
                end else begin
                    n_read_data = r_rx_q;
                    n_rx_rp     = f_next(r_rx_rp);
                    n_rx_full   = 1'b0;
                    n_acc       = 1'b1;
                end
            end
            bfmb_pkg::FUNC_TX_PUMP: begin
                if (!r_out_vld) begin
                    if (r_tx_rp == r_tx_wp) begin
                        n_drained = 1'b1;
                    end else begin
                        n_out_mb  = r_tx_q;
                        n_tx_rp   = f_next(r_tx_rp);
                        n_out_vld = 1'b1;
                        n_acc     = 1'b1;
                    end
                end
            end
            bfmb_pkg::FUNC_RX_PUMP: begin
                if (r_in_vld && !r_rx_full && (f_next(r_rx_wp) != r_rx_rp)) begin
                    rx_we     = i_cmd.exec;
                    n_rx_wp   = f_next(r_rx_wp);
                    n_in_vld  = 1'b0;
                    n_acc     = 1'b1;
                    // full once the following slot would meet the read side
                    if (f_next(f_next(r_rx_wp)) == r_rx_rp) begin
                        n_rx_full = 1'b1;
                    end
                end
            end
            bfmb_pkg::FUNC_HOST_TAKE: begin
                n_read_data = r_out_mb;
                n_acc       = r_out_vld;
                n_out_vld   = 1'b0;
            end
            bfmb_pkg::FUNC_HOST_PUT: begin
                n_in_mb  = r_data;
                n_in_vld = 1'b1;
                n_acc    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // state and result update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_rp   <= '0;
            r_tx_wp   <= '0;
            r_rx_rp   <= '0;
            r_rx_wp   <= '0;
            r_out_mb  <= '0;
            r_in_mb   <= '0;
            r_out_vld <= 1'b0;
            r_drained <= 1'b1;
            r_in_vld  <= 1'b0;
            r_rx_full <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_tx_rp   <= n_tx_rp;
                r_tx_wp   <= n_tx_wp;
                r_rx_rp   <= n_rx_rp;
                r_rx_wp   <= n_rx_wp;
                r_out_mb  <= n_out_mb;
                r_in_mb   <= n_in_mb;
                r_out_vld <= n_out_vld;
                r_drained <= n_drained;
                r_in_vld  <= n_in_vld;
                r_rx_full <= n_rx_full;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_read_data <= n_read_data;
            r_was_empty <= n_was_empty;
            r_acc       <= n_acc;
        end
    end

    assign o_done           = r_done;
    assign o_read_data      = r_read_data;
    assign o_read_was_empty = r_was_empty;
    assign o_accepted       = r_acc;
    assign o_tx_flag        = r_out_vld;
    assign o_tx_empty       = r_drained;
    assign o_rx_flag        = r_in_vld;
    assign o_rx_full        = r_rx_full;

endmodule

### verif/mailbox_bridge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mailbox_bridge_checker
// Watches the operation and result channels of the byte FIFO mailbox bridge.
// Every accepted operation is run through an independent model of both
// FIFOs and mailboxes. Each o_done result is compared field by field with
// the oldest predicted result.
// ----------------------------------------------------------------------------
module mailbox_bridge_checker #(
    parameter int DEPTH = bfmb_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [bfmb_pkg::FUNC_W-1:0] i_func,
    input  logic [bfmb_pkg::DATA_W-1:0] i_data,
    input  logic                        i_done,
    input  logic [bfmb_pkg::DATA_W-1:0] i_read_data,
    input  logic                        i_read_was_empty,
    input  logic                        i_accepted,
    input  logic                        i_tx_flag,
    input  logic                        i_tx_empty,
    input  logic                        i_rx_flag,
    input  logic                        i_rx_full,
    output int                          o_pending,
    output int                          o_ops_seen,
    output int                          o_results_seen,
    output int                          o_errors
);
    import bfmb_pkg::*;

    localparam int PTR_W     = $clog2(DEPTH);
    localparam int MAX_PRINT = 30;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              read_was_empty;
        logic              accepted;
        logic              tx_flag;
        logic              tx_empty;
        logic              rx_flag;
        logic              rx_full;
    } t_bridge_result;

    // model of the bridge state
    logic [DATA_W-1:0] tx_mem [DEPTH];
    logic [DATA_W-1:0] rx_mem [DEPTH];
    logic [PTR_W-1:0]  tx_rd;
    logic [PTR_W-1:0]  tx_wr;
    logic [PTR_W-1:0]  rx_rd;
    logic [PTR_W-1:0]  rx_wr;
    logic [DATA_W-1:0] out_box;
    logic [DATA_W-1:0] in_box;
    logic              out_valid;
    logic              tx_drained;
    logic              in_valid;
    logic              rx_full_st;

    t_bridge_result    result_q[$];

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic void clear_bridge();
        for (int k = 0; k < DEPTH; k++) begin
            tx_mem[k] = '0;
            rx_mem[k] = '0;
        end
        tx_rd      = '0;
        tx_wr      = '0;
        rx_rd      = '0;
        rx_wr      = '0;
        out_box    = '0;
        in_box     = '0;
        out_valid  = 1'b0;
        tx_drained = 1'b1;
        in_valid   = 1'b0;
        rx_full_st = 1'b0;
    endfunction

    // apply one operation to the model and return the result it produces
    function automatic t_bridge_result bridge_op(input logic [FUNC_W-1:0] op,
                                                 input logic [DATA_W-1:0] val);
        t_bridge_result r;
        r = '0;
        case (op)
            FUNC_MASTER_WRITE: begin
                if (ring_inc(tx_wr) != tx_rd) begin
                    tx_mem[tx_wr] = val;
                    tx_wr         = ring_inc(tx_wr);
                    tx_drained    = 1'b0;
                    r.accepted    = 1'b1;
                end
            end
            FUNC_MASTER_READ: begin
                if (rx_rd == rx_wr) begin
                    r.read_data      = EMPTY_BYTE;
                    r.read_was_empty = 1'b1;
                end else begin
                    r.read_data = rx_mem[rx_rd];
                    rx_rd       = ring_inc(rx_rd);
                    rx_full_st  = 1'b0;
                    r.accepted  = 1'b1;
                end
            end
            FUNC_TX_PUMP: begin
                if (!out_valid) begin
                    if (tx_rd == tx_wr) begin
                        tx_drained = 1'b1;
                    end else begin
                        out_box    = tx_mem[tx_rd];
                        tx_rd      = ring_inc(tx_rd);
                        out_valid  = 1'b1;
                        r.accepted = 1'b1;
                    end
                end
            end
            FUNC_RX_PUMP: begin
                if (in_valid && !rx_full_st && ring_inc(rx_wr) != rx_rd) begin
                    rx_mem[rx_wr] = in_box;
                    rx_wr         = ring_inc(rx_wr);
                    in_valid      = 1'b0;
                    r.accepted    = 1'b1;
                    if (ring_inc(rx_wr) == rx_rd)
                        rx_full_st = 1'b1;
                end
            end
            FUNC_HOST_TAKE: begin
                r.read_data = out_box;
                r.accepted  = out_valid;
                out_valid   = 1'b0;
            end
            FUNC_HOST_PUT: begin
                in_box     = val;
                in_valid   = 1'b1;
                r.accepted = 1'b1;
            end
            default: ;  // unused codes leave the state alone
        endcase
        r.tx_flag  = out_valid;
        r.tx_empty = tx_drained;
        r.rx_flag  = in_valid;
        r.rx_full  = rx_full_st;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (o_errors < MAX_PRINT)
            $display("ERROR %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        o_errors++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin : watch
        t_bridge_result want;
        t_bridge_result got;
        if (!i_rst_n) begin
            clear_bridge();
            result_q.delete();
            o_ops_seen     = 0;
            o_results_seen = 0;
            o_errors       = 0;
        end else begin
            // result side first: it belongs to an older transfer
            if (i_done) begin
                o_results_seen++;
                got = {i_read_data, i_read_was_empty, i_accepted,
                       i_tx_flag, i_tx_empty, i_rx_flag, i_rx_full};
                if (result_q.size() == 0) begin
                    report_mismatch("result with nothing pending", int'(got), 0);
                end else begin
                    want = result_q.pop_front();
                    check_field("read_data", int'(got.read_data), int'(want.read_data));
                    check_field("read_was_empty", int'(got.read_was_empty),
                                int'(want.read_was_empty));
                    check_field("accepted", int'(got.accepted), int'(want.accepted));
                    check_field("tx_flag", int'(got.tx_flag), int'(want.tx_flag));
                    check_field("tx_empty", int'(got.tx_empty), int'(want.tx_empty));
                    check_field("rx_flag", int'(got.rx_flag), int'(want.rx_flag));
                    check_field("rx_full", int'(got.rx_full), int'(want.rx_full));
                end
            end
            if (i_start && !i_busy) begin
                o_ops_seen++;
                result_q.push_back(bridge_op(i_func, i_data));
            end
        end
        o_pending <= result_q.size();
    end

endmodule

### verif/byte_fifo_mailbox_bridge_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_fifo_mailbox_bridge_unit_tb
// Drives operations into the mailbox bridge: a directed pass over empty and
// invalid cases, then random bursts that fill and drain both FIFOs, under
// three sender idle profiles. Checking is done by mailbox_bridge_checker.
// ----------------------------------------------------------------------------
module byte_fifo_mailbox_bridge_unit_tb;
    import bfmb_pkg::*;

    localparam int DEPTH      = FIFO_DEPTH_DEF;
    localparam int RAND_OPS   = 800;
    localparam int STALL_MAX  = 2000;
    localparam int DRAIN_WAIT = 8;

    // codes with no operation behind them
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_7 = 3'd7;

    typedef enum int {
        MIX_FILL_TX,
        MIX_DRAIN_TX,
        MIX_FILL_RX,
        MIX_DRAIN_RX,
        MIX_ANY
    } t_op_mix;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic [FUNC_W-1:0] op_func = '0;
    logic [DATA_W-1:0] op_data = '0;
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] read_data;
    logic              read_was_empty;
    logic              accepted;
    logic              tx_flag;
    logic              tx_empty;
    logic              rx_flag;
    logic              rx_full;

    int pending;
    int ops_seen;
    int results_seen;
    int errors;
    int idle_pct   = 16;
    int stall_cnt  = 0;

    always #1 i_clk = ~i_clk;

    byte_fifo_mailbox_bridge_unit #(
        .FIFO_DEPTH(DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (op_func),
        .i_data          (op_data),
        .o_done          (done),
        .o_read_data     (read_data),
        .o_read_was_empty(read_was_empty),
        .o_accepted      (accepted),
        .o_tx_flag       (tx_flag),
        .o_tx_empty      (tx_empty),
        .o_rx_flag       (rx_flag),
        .o_rx_full       (rx_full)
    );

    mailbox_bridge_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_func          (op_func),
        .i_data          (op_data),
        .i_done          (done),
        .i_read_data     (read_data),
        .i_read_was_empty(read_was_empty),
        .i_accepted      (accepted),
        .i_tx_flag       (tx_flag),
        .i_tx_empty      (tx_empty),
        .i_rx_flag       (rx_flag),
        .i_rx_full       (rx_full),
        .o_pending       (pending),
        .o_ops_seen      (ops_seen),
        .o_results_seen  (results_seen),
        .o_errors        (errors)
    );

    // one operation transfer, then a random number of idle cycles
    task automatic issue_op(input logic [FUNC_W-1:0] op, input logic [DATA_W-1:0] val);
        start   <= 1'b1;
        op_func <= op;
        op_data <= val;
        do @(posedge i_clk); while (busy);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // operation choice weighted toward the burst's goal
    function automatic logic [FUNC_W-1:0] pick_op(input t_op_mix mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL_TX:
                return (r < 80) ? FUNC_MASTER_WRITE : (r < 90) ? FUNC_TX_PUMP : FUNC_HOST_TAKE;
            MIX_DRAIN_TX:
                return (r < 47) ? FUNC_TX_PUMP : (r < 94) ? FUNC_HOST_TAKE : FUNC_MASTER_WRITE;
            MIX_FILL_RX:
                return (r < 45) ? FUNC_HOST_PUT : (r < 90) ? FUNC_RX_PUMP : FUNC_MASTER_READ;
            MIX_DRAIN_RX:
                return (r < 80) ? FUNC_MASTER_READ : (r < 90) ? FUNC_HOST_PUT : FUNC_RX_PUMP;
            default:
                return FUNC_W'($urandom_range(7));
        endcase
    endfunction

    // watchdog: no transfer on either side for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || done) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_MAX) begin
                $display("Watchdog: no transfer for %0d cycles", STALL_MAX);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        t_op_mix mix;
        int      burst_left;
        mix        = MIX_ANY;
        burst_left = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty and invalid cases, unused codes, byte extremes
        issue_op(FUNC_MASTER_READ, 8'h00);    // empty receive FIFO
        issue_op(FUNC_TX_PUMP, 8'h00);        // empty transmit FIFO
        issue_op(FUNC_HOST_TAKE, 8'h00);      // outbound mailbox not valid
        issue_op(FUNC_RX_PUMP, 8'h00);        // inbound mailbox not valid
        issue_op(FUNC_UNUSED_6, 8'hFF);
        issue_op(FUNC_UNUSED_7, 8'h00);
        issue_op(FUNC_MASTER_WRITE, 8'h00);
        issue_op(FUNC_MASTER_WRITE, 8'hFF);
        issue_op(FUNC_TX_PUMP, 8'h00);
        issue_op(FUNC_TX_PUMP, 8'h00);        // mailbox still holds a byte
        issue_op(FUNC_HOST_TAKE, 8'h00);
        issue_op(FUNC_TX_PUMP, 8'h00);
        issue_op(FUNC_HOST_TAKE, 8'h00);
        issue_op(FUNC_HOST_TAKE, 8'h00);      // take twice: stale byte shows
        issue_op(FUNC_HOST_PUT, 8'hA5);
        issue_op(FUNC_HOST_PUT, 8'h5A);       // overwrite of a valid inbound byte
        issue_op(FUNC_RX_PUMP, 8'h00);
        issue_op(FUNC_HOST_PUT, 8'hFF);
        issue_op(FUNC_RX_PUMP, 8'h00);
        issue_op(FUNC_MASTER_READ, 8'h00);
        issue_op(FUNC_MASTER_READ, 8'h00);
        issue_op(FUNC_MASTER_READ, 8'h00);    // empty again

        // random bursts, three idle profiles
        for (int n = 0; n < RAND_OPS; n++) begin
            idle_pct = (n < RAND_OPS / 3) ? 16 : (n < 2 * RAND_OPS / 3) ? 85 : 0;
            if (burst_left == 0) begin
                mix        = t_op_mix'($urandom_range(4));
                burst_left = $urandom_range(8, 36);
            end
            burst_left--;
            issue_op(pick_op(mix), DATA_W'($urandom_range(255)));
        end
        start <= 1'b0;

        // wait out the outstanding results
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Run covered %0d operations and %0d checked results", ops_seen, results_seen);
        $display("Fill/drain bursts on both FIFOs at 16%%, 85%% and no sender idling");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
